FILE: rtl/ust_pkg.sv
// Shared types and constants for the serial transmitter.
package ust_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned DataW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned CountW  = 19;
  localparam int unsigned BitIdxW = 4;

  // Input word function codes
  localparam logic [FuncW-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_WR_LO = 2'd1;
  localparam logic [FuncW-1:0] FUNC_WR_HI = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BAUD   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAR_EN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAR_EV = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NINTH  = 3'd4;

  // Frame positions
  localparam logic [BitIdxW-1:0] POS_START = 4'd0;
  localparam logic [BitIdxW-1:0] POS_LAST  = 4'd8;
  localparam logic [BitIdxW-1:0] POS_NINTH = 4'd9;
  localparam logic [BitIdxW-1:0] POS_STOP  = 4'd10;

  // Line and flag values seen after one word
  typedef struct packed {
    logic txd;
    logic transmit_done;
    logic transmitter_empty;
  } ust_status_t;

endpackage

FILE: rtl/ust_if.sv
// Handshake channel interfaces: input words, result words, configuration writes.
interface ust_in_if;
  import ust_pkg::*;
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [DataW-1:0] data;
  modport source (output valid, func, data, input ready);
  modport sink   (input valid, func, data, output ready);
endinterface

interface ust_out_if;
  logic valid;
  logic ready;
  logic txd;
  logic transmit_done;
  logic transmitter_empty;
  modport source (output valid, txd, transmit_done, transmitter_empty, input ready);
  modport sink   (input valid, txd, transmit_done, transmitter_empty, output ready);
endinterface

interface ust_cfg_if;
  import ust_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/ust_core.sv
// Transmitter state: baud divider, frame sequencer, double buffer and status flags.
module ust_core import ust_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [FuncW-1:0]   func_i,
  input  logic [DataW-1:0]   data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output ust_status_t        status_o
);

  logic [2:0]         mode_q;
  logic [CfgDatW-1:0] baud_q;
  logic               par_en_q, par_ev_q, ninth_q;

  logic [CountW-1:0]  cnt_q, cnt_d, cnt_inc, period;
  logic [BitIdxW-1:0] idx_q, idx_d;
  logic [DataW-1:0]   sr_q, sr_d, buf_q, buf_d;
  logic               bp_q, bp_d, sp_q, sp_d, par_q, par_d;
  logic               line_q, line_d, ti_q, ti_d, txe_q, txe_d;
  logic               framed, ninth_en;

  assign framed   = mode_q[0];
  assign ninth_en = mode_q[1];
  assign cnt_inc  = cnt_q + CountW'(1);
  assign period   = {CountW'({1'b0, baud_q[14:0]}) + CountW'(1)} << 3;

  always_comb begin
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    sr_d   = sr_q;
    buf_d  = buf_q;
    bp_d   = bp_q;
    sp_d   = sp_q;
    par_d  = par_q;
    line_d = line_q;
    ti_d   = ti_q;
    txe_d  = txe_q;
    case (func_i)
      FUNC_TICK: begin
        if (baud_q != '0) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= period) begin
            cnt_d = '0;
            if (sp_q) begin
              if (idx_q == POS_START && framed) begin
                line_d = 1'b0;
                idx_d  = idx_q + BitIdxW'(1);
                par_d  = 1'b0;
              end else if (idx_q <= POS_LAST && framed) begin
                line_d = sr_q[0];
                par_d  = par_q ^ sr_q[0];
                sr_d   = sr_q >> 1;
                idx_d  = idx_q + BitIdxW'(1);
              end else if (idx_q == POS_NINTH && ninth_en) begin
                // Ninth bit: parity or fixed level
                line_d = par_en_q ? (par_ev_q ? par_q : ~par_q) : ninth_q;
                idx_d  = POS_STOP;
              end else if (idx_q >= POS_NINTH && framed) begin
                line_d = 1'b1;
                ti_d   = 1'b1;
                idx_d  = POS_START;
                sp_d   = 1'b0;
                if (bp_q) begin
                  sr_d = buf_q;
                  bp_d = 1'b0;
                  sp_d = 1'b1;
                end else begin
                  txe_d = 1'b1;
                end
              end
            end
          end
        end
      end
      FUNC_WR_LO: begin
        buf_d = data_i;
        if (txe_q) begin
          sr_d  = data_i;
          sp_d  = 1'b1;
          txe_d = 1'b0;
          bp_d  = 1'b0;
        end else begin
          bp_d  = 1'b1;
          ti_d  = 1'b0;
          txe_d = 1'b0;
        end
      end
      FUNC_WR_HI: begin
        buf_d = data_i;
        bp_d  = 1'b1;
        ti_d  = 1'b0;
        txe_d = 1'b0;
      end
      default: ;
    endcase
  end

  assign status_o = '{txd: line_d, transmit_done: ti_d, transmitter_empty: txe_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      baud_q   <= '0;
      par_en_q <= 1'b0;
      par_ev_q <= 1'b0;
      ninth_q  <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= POS_START;
      sr_q     <= '0;
      buf_q    <= '0;
      bp_q     <= 1'b0;
      sp_q     <= 1'b0;
      par_q    <= 1'b0;
      line_q   <= 1'b1;
      ti_q     <= 1'b0;
      txe_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE:   mode_q   <= cfg_data_i[2:0];
          CFG_BAUD:   baud_q   <= cfg_data_i;
          CFG_PAR_EN: par_en_q <= cfg_data_i[0];
          CFG_PAR_EV: par_ev_q <= cfg_data_i[0];
          CFG_NINTH:  ninth_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (step_i) begin
        cnt_q  <= cnt_d;
        idx_q  <= idx_d;
        sr_q   <= sr_d;
        buf_q  <= buf_d;
        bp_q   <= bp_d;
        sp_q   <= sp_d;
        par_q  <= par_d;
        line_q <= line_d;
        ti_q   <= ti_d;
        txe_q  <= txe_d;
      end
    end
  end

  // Empty transmitter holds nothing in either buffer stage
  a_txe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    txe_q |-> (!sp_q && !bp_q))
    else $error("TXE set while a word is still queued");

  // Frame position never passes the stop slot
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= POS_STOP)
    else $error("frame position out of range");

  // Halted divider leaves counter and line untouched on a tick
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && func_i == FUNC_TICK && baud_q == '0) |=> ($stable(cnt_q) && $stable(line_q)))
    else $error("tick advanced a halted divider");

endmodule

FILE: rtl/uart_serial_transmitter_unit.sv
// Top level of the serial transmitter: handshake channels and result register.
//
// Channels:
//   req_i  - input words; func selects a baud tick, a low buffer write or a
//            high buffer write, data carries the byte for buffer writes.
//   rsp_o  - result words, one per input word: the transmit line level and
//            the TI and TXE flags as they stand after that word.
//   cfg_i  - register writes (mode, baud compare, parity enable, parity
//            sense, fixed ninth bit); always ready, applied at once.
// Result words are registered, in the cycle after the input word is taken.
// Throughput: one word per cycle while rsp_o.ready is high; the next-state
// logic of ust_core is a single combinational pass between the state
// registers and the result register.
// Stalls: the result register holds while rsp_o.ready is low; an input word
// is still taken in the same cycle that the held result leaves, so nothing
// is lost when the receiver stalls and no bubble appears when it does not.
// Reset: rst_ni clears all registers but the result payload; the line idles
// high, TXE is set, TI is clear, the divider is halted and the result register is empty.
module uart_serial_transmitter_unit import ust_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ust_in_if.sink    req_i,
  ust_out_if.source rsp_o,
  ust_cfg_if.sink   cfg_i
);

  logic        accept;
  logic        out_valid_q;
  ust_status_t status_d, status_q;

  // Take a word whenever the result register is empty or being drained
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  ust_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .func_i     (req_i.func),
    .data_i     (req_i.data),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.wdata),
    .status_o   (status_d)
  );

  // Valid bit of the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      out_valid_q <= req_i.valid;
    end
  end

  // Result payload; load only on an accepted word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.txd               = status_q.txd;
  assign rsp_o.transmit_done     = status_q.transmit_done;
  assign rsp_o.transmitter_empty = status_q.transmitter_empty;

endmodule

FILE: test/uart_serial_transmitter_unit_test.sv
// Testbench for the serial transmitter: line level and TI/TXE flags checked word by word.
`timescale 1ns / 1ps

module uart_serial_transmitter_unit_test;
  import ust_pkg::*;

  // The package names three function codes; the fourth does nothing.
  localparam logic [FuncW-1:0] FUNC_UNUSED   = 2'd3;
  localparam int unsigned      MaxReports    = 10;
  localparam int unsigned      RandomPhases  = 12;
  localparam int unsigned      WordsPerPhase = 65;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ust_in_if  req();
  ust_out_if rsp();
  ust_cfg_if cfg();

  uart_serial_transmitter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  always #5 clk_i = ~clk_i;

  // Percent of cycles the sender idles and the receiver stalls.
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned fault_count;

  // Mirror of the register file.
  logic [2:0]         mode_q;
  logic [CfgDatW-1:0] compare_q;
  logic               par_en_q;
  logic               par_even_q;
  logic               ninth_q;

  // Mirror of the transmitter state.
  logic [CountW-1:0]  div_count;
  logic [BitIdxW-1:0] frame_pos;
  logic [DataW-1:0]   shift_byte;
  logic [DataW-1:0]   hold_byte;
  logic               hold_full;
  logic               shift_busy;
  logic               par_acc;
  logic               line_lvl;
  logic               ti_flag;
  logic               txe_flag;

  // Line status words still owed by the block, oldest first.
  ust_status_t status_due[$];

  function automatic void reset_transmitter();
    mode_q     = '0;
    compare_q  = '0;
    par_en_q   = 1'b0;
    par_even_q = 1'b0;
    ninth_q    = 1'b0;
    div_count  = '0;
    frame_pos  = POS_START;
    shift_byte = '0;
    hold_byte  = '0;
    hold_full  = 1'b0;
    shift_busy = 1'b0;
    par_acc    = 1'b0;
    line_lvl   = 1'b1;
    ti_flag    = 1'b0;
    txe_flag   = 1'b1;
  endfunction

  // Move the frame one bit along at the end of a bit period. With framing off the
  // position holds, but a pending ninth bit still goes out when mode bit1 is set.
  function automatic void shift_out_bit();
    if (frame_pos == POS_START && mode_q[0]) begin
      line_lvl  = 1'b0;
      frame_pos = frame_pos + 1'b1;
      par_acc   = 1'b0;
    end else if (frame_pos <= POS_LAST && mode_q[0]) begin
      line_lvl   = shift_byte[0];
      par_acc    = par_acc ^ shift_byte[0];
      shift_byte = shift_byte >> 1;
      frame_pos  = frame_pos + 1'b1;
    end else if (frame_pos == POS_NINTH && mode_q[1]) begin
      // Even parity repeats the running parity, odd parity inverts it.
      line_lvl  = par_en_q ? (par_acc ^ ~par_even_q) : ninth_q;
      frame_pos = POS_STOP;
    end else if (frame_pos >= POS_NINTH && mode_q[0]) begin
      // Stop bit: set TI, then reload from the buffer or report empty.
      line_lvl   = 1'b1;
      ti_flag    = 1'b1;
      frame_pos  = POS_START;
      shift_busy = 1'b0;
      if (hold_full) begin
        shift_byte = hold_byte;
        hold_full  = 1'b0;
        shift_busy = 1'b1;
      end else begin
        txe_flag = 1'b1;
      end
    end
  endfunction

  // Advance the mirror by one input word and return the status it leaves behind.
  function automatic ust_status_t step_transmitter(logic [FuncW-1:0] func,
                                                   logic [DataW-1:0] data);
    int unsigned period;
    ust_status_t st;
    case (func)
      FUNC_TICK: begin
        // A zero compare halts the divider; bit15 of the compare is ignored in the period.
        if (compare_q != '0) begin
          div_count = div_count + 1'b1;
          period    = (32'(compare_q[14:0]) + 32'd1) * 32'd8;
          if (32'(div_count) >= period) begin
            div_count = '0;
            if (shift_busy) shift_out_bit();
          end
        end
      end
      FUNC_WR_LO: begin
        hold_byte = data;
        if (txe_flag) begin
          shift_byte = data;
          shift_busy = 1'b1;
          txe_flag   = 1'b0;
          hold_full  = 1'b0;
        end else begin
          hold_full = 1'b1;
          ti_flag   = 1'b0;
          txe_flag  = 1'b0;
        end
      end
      FUNC_WR_HI: begin
        // Always parks in the buffer, even with the shifter idle.
        hold_byte = data;
        hold_full = 1'b1;
        ti_flag   = 1'b0;
        txe_flag  = 1'b0;
      end
      default: ;
    endcase
    st.txd               = line_lvl;
    st.transmit_done     = ti_flag;
    st.transmitter_empty = txe_flag;
    return st;
  endfunction

  // Receiver side: stall at random, one decision per cycle.
  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result word with the oldest owed status.
  always @(posedge clk_i) begin
    ust_status_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (status_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MaxReports)
          $display("%0t: result word with nothing owed: txd %b ti %b txe %b",
                   $time, rsp.txd, rsp.transmit_done, rsp.transmitter_empty);
      end else begin
        want = status_due.pop_front();
        if (rsp.txd !== want.txd || rsp.transmit_done !== want.transmit_done ||
            rsp.transmitter_empty !== want.transmitter_empty) begin
          fault_count++;
          if (fault_count <= MaxReports)
            $display("%0t: status mismatch (expected/actual): txd %b/%b ti %b/%b txe %b/%b",
                     $time, want.txd, rsp.txd, want.transmit_done, rsp.transmit_done,
                     want.transmitter_empty, rsp.transmitter_empty);
        end
      end
    end
  end

  // Offer one word, hold it until taken, then record what it should produce.
  // Valid stays high on return so back-to-back words never drop it.
  task automatic send_word(input logic [FuncW-1:0] func, input logic [DataW-1:0] data);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.func  <= func;
    req.data  <= data;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    status_due.push_back(step_transmitter(func, data));
  endtask

  // Hold off the sender until every owed status word has come back.
  task automatic drain_results();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (status_due.size() != 0);
  endtask

  // Write all five registers in index order; call only with the block drained.
  task automatic load_settings(input logic [2:0] mode, input logic [CfgDatW-1:0] compare,
                               input logic par_en, input logic par_even, input logic ninth);
    logic [CfgIdxW-1:0] idx [5];
    logic [CfgDatW-1:0] val [5];
    idx = '{CFG_MODE, CFG_BAUD, CFG_PAR_EN, CFG_PAR_EV, CFG_NINTH};
    val = '{CfgDatW'(mode), compare, CfgDatW'(par_en), CfgDatW'(par_even), CfgDatW'(ninth)};
    for (int i = 0; i < 5; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[i];
      cfg.wdata <= val[i];
      @(posedge clk_i);
      while (!cfg.ready) @(posedge clk_i);
      case (idx[i])
        CFG_MODE:   mode_q     = val[i][2:0];
        CFG_BAUD:   compare_q  = val[i];
        CFG_PAR_EN: par_en_q   = val[i][0];
        CFG_PAR_EV: par_even_q = val[i][0];
        CFG_NINTH:  ninth_q    = val[i][0];
        default: ;
      endcase
    end
    cfg.valid <= 1'b0;
  endtask

  // Out of reset the divider is halted: ticks and the unused code change
  // nothing, while buffer writes still move the flags.
  task automatic test_halted_divider();
    gap_pct   = 0;
    stall_pct = 0;
    send_word(FUNC_TICK, 8'h00);
    send_word(FUNC_TICK, 8'hFF);
    send_word(FUNC_UNUSED, 8'hA5);
    send_word(FUNC_WR_LO, 8'h00);  // shifter idle: load it directly
    send_word(FUNC_TICK, 8'h5A);
    send_word(FUNC_WR_LO, 8'hFF);  // shifter busy: park in buffer, clear flags
    send_word(FUNC_WR_LO, 8'h81);  // overwrite the parked byte
  endtask

  // Run the counter up under the slowest divider, then drop the compare below
  // the count: the very next tick must close the bit period.
  task automatic test_compare_lowered();
    drain_results();
    load_settings(3'd3, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    repeat (12) send_word(FUNC_TICK, 8'($urandom));
    drain_results();
    load_settings(3'd3, 16'h8000, 1'b1, 1'b0, 1'b0);
    repeat (2) send_word(FUNC_TICK, 8'($urandom));
    send_word(FUNC_WR_HI, 8'hFF);  // high write behind a running frame
  endtask

  // Mostly ticks under short bit periods so frames complete; refill the
  // shifter whenever it runs dry, with some noise and buffer churn mixed in.
  task automatic test_random_traffic();
    logic [2:0]         mode;
    logic [CfgDatW-1:0] compare;
    int unsigned        pick;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain_results();
      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 70; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 70; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      case (phase)
        0: begin mode = 3'd7; compare = 16'h8000; end
        4: begin mode = 3'd0; compare = 16'd1;    end  // framing off
        6: begin mode = 3'd1; compare = '1;       end  // slowest divider
        8: begin mode = 3'd2; compare = '0;       end  // halted
        default: begin
          mode = 3'($urandom_range(7));
          if ($urandom_range(3) != 0) mode[0] = 1'b1;
          pick = $urandom_range(9);
          if (pick < 4)      compare = 16'h8000;
          else if (pick < 7) compare = 16'd1;
          else if (pick < 9) compare = 16'($urandom_range(3, 2)) | 16'h8000;
          else               compare = 16'($urandom);
        end
      endcase
      load_settings(mode, compare, 1'($urandom), 1'($urandom), 1'($urandom));
      for (int n = 0; n < WordsPerPhase; n++) begin
        pick = $urandom_range(99);
        if (txe_flag && pick < 50) begin
          send_word(FUNC_WR_LO, 8'($urandom));
        end else if (pick < 54 && shift_busy) begin
          // Only behind a running frame; with the shifter idle it would wedge.
          send_word(FUNC_WR_HI, 8'($urandom));
        end else if (pick < 59) begin
          send_word(FUNC_WR_LO, 8'($urandom));
        end else if (pick < 61) begin
          send_word(FUNC_UNUSED, 8'($urandom));
        end else begin
          send_word(FUNC_TICK, 8'($urandom));
        end
      end
    end
  endtask

  // Let the transmitter go idle, then write the high byte: it parks for good
  // since no frame will ever end to pick it up. Run this one last.
  task automatic test_high_write_when_idle();
    int unsigned guard;
    gap_pct   = 12;
    stall_pct = 12;
    drain_results();
    load_settings(3'd1, 16'h8000, 1'b0, 1'b0, 1'b0);
    guard = 0;
    while (!txe_flag && guard < 2000) begin
      send_word(FUNC_TICK, 8'($urandom));
      guard++;
    end
    send_word(FUNC_WR_HI, 8'hC3);
    repeat (20) send_word(FUNC_TICK, 8'($urandom));
    send_word(FUNC_WR_LO, 8'h3C);
    repeat (30) send_word(FUNC_TICK, 8'($urandom));
  endtask

  initial begin
    req.valid <= 1'b0;
    req.func  <= FUNC_TICK;
    req.data  <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_MODE;
    cfg.wdata <= '0;
    gap_pct     = 0;
    stall_pct   = 0;
    fault_count = 0;
    reset_transmitter();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_halted_divider();
    test_compare_lowered();
    test_random_traffic();
    test_high_write_when_idle();

    // Settle: everything owed back, then wait for any stray words.
    drain_results();
    repeat (4) @(posedge clk_i);
    fault_count += status_due.size();

    if (fault_count == 0) begin
      $display("uart_serial_transmitter_unit_test: done, clean");
    end else begin
      $display("uart_serial_transmitter_unit_test: done, errors");
    end
    $finish;
  end

  // Backstop against a hung handshake.
  initial begin
    #(5_000_000);
    $display("uart_serial_transmitter_unit_test: done, errors");
    $finish;
  end

endmodule
